@@ rtl/pett_pkg.sv @@
// Shared types, widths and codes for the periodic event timer table.
package pett_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_FIRINGS = 16;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int FIRE_CNT_W = $clog2(MAX_FIRINGS + 1);

    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 8;
    localparam int VALUE_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SERVICE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_NORMAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ADD_HIGH   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ADD_ONCE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REM_SLOT   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_REM_HANDLE = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic pending;
        logic oneshot;
        logic high;
    } marks_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  argument;
        logic [VALUE_W-1:0]  period;
        logic [VALUE_W-1:0]  countdown;
        marks_t              marks;
    } entry_t;

    typedef struct packed {
        logic   keep;
        logic   fire;
        logic   urgent;
        entry_t ent;
    } unit_res_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/pett_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/pett_unit.sv @@
// Per-entry update unit: countdown, firing, pending marks and keep/drop decision.
module pett_unit (
    input  logic [pett_pkg::KIND_W-1:0]   kind,
    input  logic [pett_pkg::HANDLE_W-1:0] handle,
    input  logic [pett_pkg::SLOT_W-1:0]   slot,
    input  logic [pett_pkg::IDX_W-1:0]    idx,
    input  pett_pkg::entry_t              ent_in,
    output pett_pkg::unit_res_t           res
);
    import pett_pkg::*;

    always_comb
    begin
        res.keep   = 1'b1;
        res.fire   = 1'b0;
        res.urgent = 1'b0;
        res.ent    = ent_in;
        case (kind)
            KIND_TICK:
            begin
                if (ent_in.countdown != '0)
                begin
                    res.ent.countdown = ent_in.countdown - VALUE_W'(1);
                end
                else
                begin
                    res.ent.countdown = ent_in.period;
                    if (ent_in.marks.high)
                    begin
                        res.fire   = 1'b1;
                        res.urgent = 1'b1;
                    end
                    else
                    begin
                        res.ent.marks.pending = 1'b1;
                    end
                end
            end
            KIND_SERVICE:
            begin
                if (ent_in.marks.pending && !ent_in.marks.high)
                begin
                    res.fire              = 1'b1;
                    res.ent.marks.pending = 1'b0;
                    res.keep              = !ent_in.marks.oneshot;
                end
            end
            KIND_REM_SLOT:
            begin
                res.keep = (CMP_W'(idx) != CMP_W'(slot));
            end
            KIND_REM_HANDLE:
            begin
                res.keep = (ent_in.handle != handle);
            end
            default:
            begin
                res.keep = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/periodic_event_timer_table.sv @@
// Top level: command port, table sequencer, table RAM and result register.
//
// channel   direction  handshake            payload
// command   in         start && !busy       kind, handle, period, argument, slot
// result    out        strobe (one cycle)   fired, fired_handle, fired_argument,
//                                           fired_urgent, status, occupancy, last
//
// Tick, service and both removals walk the table once through its single read
// port and compact it through the write port. Add and clear go straight to the
// final status, and so does an out-of-range slot removal.
// Each result shows on the output register in the cycle after it is formed, and
// the receiver cannot stall, so the next command may enter while the final
// status is still on the ports. Reset empties the table at once.
module periodic_event_timer_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pett_pkg::KIND_W-1:0]    kind,
    input  logic [pett_pkg::HANDLE_W-1:0]  handle,
    input  logic [pett_pkg::VALUE_W-1:0]   period,
    input  logic [pett_pkg::VALUE_W-1:0]   argument,
    input  logic [pett_pkg::SLOT_W-1:0]    slot,
    output logic                           strobe,
    output logic                           fired,
    output logic [pett_pkg::HANDLE_W-1:0]  fired_handle,
    output logic [pett_pkg::VALUE_W-1:0]   fired_argument,
    output logic                           fired_urgent,
    output logic [pett_pkg::STATUS_W-1:0]  status,
    output logic [pett_pkg::OCC_W-1:0]     occupancy,
    output logic                           last
);
    import pett_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    // control state
    logic [1:0]            state_reg,    state_next;
    logic [CNT_W-1:0]      total_reg,    total_next;
    logic [CNT_W-1:0]      pos_cnt_reg,  pos_cnt_next;
    logic [CNT_W-1:0]      rd_cnt_reg,   rd_cnt_next;
    logic [CNT_W-1:0]      wr_cnt_reg,   wr_cnt_next;
    logic                  p_vld_reg,    p_vld_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                  strobe_reg,   strobe_next;

    // payload
    logic [KIND_W-1:0]     kind_reg,     kind_next;
    logic [HANDLE_W-1:0]   handle_reg,   handle_next;
    logic [SLOT_W-1:0]     slot_reg,     slot_next;
    logic [IDX_W-1:0]      p_idx_reg,    p_idx_next;
    logic [CNT_W-1:0]      occ_reg,      occ_next;
    logic [STATUS_W-1:0]   status_reg,   status_next;
    logic                  o_fired_reg,  o_fired_next;
    logic [HANDLE_W-1:0]   o_handle_reg, o_handle_next;
    logic [VALUE_W-1:0]    o_arg_reg,    o_arg_next;
    logic                  o_urgent_reg, o_urgent_next;
    logic [STATUS_W-1:0]   o_status_reg, o_status_next;
    logic [OCC_W-1:0]      o_occ_reg,    o_occ_next;
    logic                  o_last_reg,   o_last_next;

    // table port
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    entry_t                ram_wr_data;
    logic                  ram_rd_en;
    logic [ENTRY_W-1:0]    ram_rd_raw;
    entry_t                rd_ent;
    unit_res_t             unit_res;

    assign rd_ent = entry_t'(ram_rd_raw);

    pett_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ENTRY_W'(ram_wr_data)),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_raw)
    );

    pett_unit u_unit (
        .kind   (kind_reg),
        .handle (handle_reg),
        .slot   (slot_reg),
        .idx    (p_idx_reg),
        .ent_in (rd_ent),
        .res    (unit_res)
    );

    always_comb
    begin
        logic issue;
        logic old_pos;
        logic new_pos;

        state_next    = state_reg;
        total_next    = total_reg;
        pos_cnt_next  = pos_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        wr_cnt_next   = wr_cnt_reg;
        p_vld_next    = 1'b0;
        fire_cnt_next = fire_cnt_reg;
        strobe_next   = 1'b0;

        kind_next     = kind_reg;
        handle_next   = handle_reg;
        slot_next     = slot_reg;
        p_idx_next    = rd_cnt_reg[IDX_W-1:0];
        occ_next      = occ_reg;
        status_next   = status_reg;
        o_fired_next  = o_fired_reg;
        o_handle_next = o_handle_reg;
        o_arg_next    = o_arg_reg;
        o_urgent_next = o_urgent_reg;
        o_status_next = o_status_reg;
        o_occ_next    = o_occ_reg;
        o_last_next   = o_last_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_cnt_reg[IDX_W-1:0];
        ram_wr_data = unit_res.ent;
        ram_rd_en   = 1'b0;

        issue   = 1'b0;
        old_pos = 1'b0;
        new_pos = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    handle_next   = handle;
                    slot_next     = slot;
                    rd_cnt_next   = '0;
                    wr_cnt_next   = '0;
                    fire_cnt_next = '0;
                    status_next   = STATUS_OK;
                    occ_next      = total_reg;
                    state_next    = S_WALK;
                    case (kind)
                        KIND_TICK:
                        begin
                            occ_next = total_reg;
                        end
                        KIND_SERVICE:
                        begin
                            // every pending one-shot entry leaves during service
                            occ_next = total_reg - pos_cnt_reg;
                        end
                        KIND_ADD_NORMAL, KIND_ADD_HIGH, KIND_ADD_ONCE:
                        begin
                            state_next = S_FINAL;
                            if (handle == '0)
                            begin
                                status_next = STATUS_NULL;
                            end
                            else if (total_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr_en                = 1'b1;
                                ram_wr_addr              = total_reg[IDX_W-1:0];
                                ram_wr_data.handle       = handle;
                                ram_wr_data.argument     = argument;
                                ram_wr_data.period       = period;
                                ram_wr_data.countdown    = period;
                                ram_wr_data.marks.pending = 1'b0;
                                ram_wr_data.marks.oneshot = (kind == KIND_ADD_ONCE);
                                ram_wr_data.marks.high    = (kind == KIND_ADD_HIGH);
                                total_next               = total_reg + CNT_W'(1);
                            end
                        end
                        KIND_REM_SLOT:
                        begin
                            if (CMP_W'(slot) >= CMP_W'(total_reg))
                            begin
                                status_next = STATUS_NOT_FOUND;
                                state_next  = S_FINAL;
                            end
                        end
                        KIND_REM_HANDLE:
                        begin
                            occ_next = total_reg;
                        end
                        default:
                        begin
                            total_next   = '0;
                            pos_cnt_next = '0;
                            state_next   = S_FINAL;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                issue = (rd_cnt_reg < total_reg);
                if (issue)
                begin
                    ram_rd_en   = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                p_vld_next = issue;

                if (p_vld_reg)
                begin
                    old_pos = rd_ent.marks.pending && rd_ent.marks.oneshot;
                    new_pos = unit_res.keep && unit_res.ent.marks.pending
                              && unit_res.ent.marks.oneshot;
                    pos_cnt_next = pos_cnt_reg + CNT_W'(new_pos) - CNT_W'(old_pos);
                    // compact: survivors slide down to the write pointer
                    if (unit_res.keep)
                    begin
                        ram_wr_en   = 1'b1;
                        wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                    end
                    if (unit_res.fire && (fire_cnt_reg < FIRE_CNT_W'(MAX_FIRINGS)))
                    begin
                        fire_cnt_next = fire_cnt_reg + FIRE_CNT_W'(1);
                        strobe_next   = 1'b1;
                        o_fired_next  = 1'b1;
                        o_handle_next = rd_ent.handle;
                        o_arg_next    = rd_ent.argument;
                        o_urgent_next = unit_res.urgent;
                        o_status_next = STATUS_OK;
                        o_occ_next    = OCC_W'(occ_reg);
                        o_last_next   = 1'b0;
                    end
                end

                if (!issue && !p_vld_reg)
                begin
                    total_next = wr_cnt_reg;
                    state_next = S_FINAL;
                    if ((kind_reg == KIND_REM_HANDLE) && (wr_cnt_reg == total_reg))
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
            end

            S_FINAL:
            begin
                strobe_next   = 1'b1;
                o_fired_next  = 1'b0;
                o_handle_next = '0;
                o_arg_next    = '0;
                o_urgent_next = 1'b0;
                o_status_next = status_reg;
                o_occ_next    = OCC_W'(total_reg);
                o_last_next   = 1'b1;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            pos_cnt_reg  <= '0;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            p_vld_reg    <= 1'b0;
            fire_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            pos_cnt_reg  <= pos_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            wr_cnt_reg   <= wr_cnt_next;
            p_vld_reg    <= p_vld_next;
            fire_cnt_reg <= fire_cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        handle_reg   <= handle_next;
        slot_reg     <= slot_next;
        p_idx_reg    <= p_idx_next;
        occ_reg      <= occ_next;
        status_reg   <= status_next;
        o_fired_reg  <= o_fired_next;
        o_handle_reg <= o_handle_next;
        o_arg_reg    <= o_arg_next;
        o_urgent_reg <= o_urgent_next;
        o_status_reg <= o_status_next;
        o_occ_reg    <= o_occ_next;
        o_last_reg   <= o_last_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign strobe         = strobe_reg;
    assign fired          = o_fired_reg;
    assign fired_handle   = o_handle_reg;
    assign fired_argument = o_arg_reg;
    assign fired_urgent   = o_urgent_reg;
    assign status         = o_status_reg;
    assign occupancy      = o_occ_reg;
    assign last           = o_last_reg;

endmodule

@@ test/tb_periodic_event_timer_table.sv @@
`timescale 1ns / 1ps
// Testbench for the event timer table: directed and random commands checked against a table model.
module tb_periodic_event_timer_table;
    import pett_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_ITEMS  = 78;
    localparam int MAX_ERR_LINES = 40;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  period;
        logic [VALUE_W-1:0]  argument;
        logic [SLOT_W-1:0]   slot;
        int                  gap;
    } command_t;

    typedef struct packed {
        logic                fired;
        logic [HANDLE_W-1:0] fired_handle;
        logic [VALUE_W-1:0]  fired_argument;
        logic                fired_urgent;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
        logic                last;
    } outcome_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                start    = 1'b0;
    logic [KIND_W-1:0]   kind     = '0;
    logic [HANDLE_W-1:0] handle   = '0;
    logic [VALUE_W-1:0]  period   = '0;
    logic [VALUE_W-1:0]  argument = '0;
    logic [SLOT_W-1:0]   slot     = '0;
    logic                busy;
    logic                strobe;
    logic                fired;
    logic [HANDLE_W-1:0] fired_handle;
    logic [VALUE_W-1:0]  fired_argument;
    logic                fired_urgent;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                last;

    command_t cmd_backlog[$];
    outcome_t due_results[$];
    int       n_sent     = 0;
    int       n_taken    = 0;
    int       gap_left   = 0;
    int       mismatches = 0;
    int       steady_left = 0;

    // table model
    entry_t tbl [TABLE_DEPTH];
    int     tbl_count = 0;

    periodic_event_timer_table uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .handle         (handle),
        .period         (period),
        .argument       (argument),
        .slot           (slot),
        .strobe         (strobe),
        .fired          (fired),
        .fired_handle   (fired_handle),
        .fired_argument (fired_argument),
        .fired_urgent   (fired_urgent),
        .status         (status),
        .occupancy      (occupancy),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_ERR_LINES)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    function automatic outcome_t fire_of(input entry_t e, input logic urgent);
        outcome_t o;
        o = '0;
        o.fired          = 1'b1;
        o.fired_handle   = e.handle;
        o.fired_argument = e.argument;
        o.fired_urgent   = urgent;
        o.status         = STATUS_OK;
        return o;
    endfunction

    // Close the gap at pos, keeping order.
    task automatic drop_slot(input int pos);
        for (int j = pos; j + 1 < tbl_count; j++)
            tbl[j] = tbl[j + 1];
        tbl_count--;
    endtask

    task automatic advance_table(input command_t c);
        outcome_t            fires[$];
        outcome_t            o;
        logic [STATUS_W-1:0] st;
        int                  i;
        bit                  hit;
        st  = STATUS_OK;
        hit = 1'b0;
        case (c.kind)
            KIND_TICK:
            begin
                for (i = 0; i < tbl_count; i++)
                begin
                    if (tbl[i].countdown != '0)
                        tbl[i].countdown = tbl[i].countdown - VALUE_W'(1);
                    else
                    begin
                        tbl[i].countdown = tbl[i].period;
                        if (tbl[i].marks.high)
                        begin
                            if (fires.size() < MAX_FIRINGS)
                                fires.push_back(fire_of(tbl[i], 1'b1));
                        end
                        else
                            tbl[i].marks.pending = 1'b1;
                    end
                end
            end
            KIND_SERVICE:
            begin
                i = 0;
                while (i < tbl_count)
                begin
                    if (tbl[i].marks.pending && !tbl[i].marks.high)
                    begin
                        if (fires.size() < MAX_FIRINGS)
                            fires.push_back(fire_of(tbl[i], 1'b0));
                        tbl[i].marks.pending = 1'b0;
                        // the entry sliding into i is examined next
                        if (tbl[i].marks.oneshot)
                            drop_slot(i);
                        else
                            i++;
                    end
                    else
                        i++;
                end
            end
            KIND_ADD_NORMAL, KIND_ADD_HIGH, KIND_ADD_ONCE:
            begin
                if (c.handle == '0)
                    st = STATUS_NULL;
                else if (tbl_count >= TABLE_DEPTH)
                    st = STATUS_FULL;
                else
                begin
                    tbl[tbl_count].handle        = c.handle;
                    tbl[tbl_count].argument      = c.argument;
                    tbl[tbl_count].period        = c.period;
                    tbl[tbl_count].countdown     = c.period;
                    tbl[tbl_count].marks         = '0;
                    tbl[tbl_count].marks.high    = (c.kind == KIND_ADD_HIGH);
                    tbl[tbl_count].marks.oneshot = (c.kind == KIND_ADD_ONCE);
                    tbl_count++;
                end
            end
            KIND_REM_SLOT:
            begin
                if (int'(c.slot) >= tbl_count)
                    st = STATUS_NOT_FOUND;
                else
                    drop_slot(int'(c.slot));
            end
            KIND_REM_HANDLE:
            begin
                i = 0;
                while (i < tbl_count)
                begin
                    if (tbl[i].handle == c.handle)
                    begin
                        drop_slot(i);
                        hit = 1'b1;
                    end
                    else
                        i++;
                end
                if (!hit)
                    st = STATUS_NOT_FOUND;
            end
            KIND_CLEAR:
                tbl_count = 0;
            default:
                tbl_count = 0;
        endcase
        while (fires.size() != 0)
        begin
            o = fires.pop_front();
            o.occupancy = OCC_W'(tbl_count);
            due_results.push_back(o);
        end
        o = '0;
        o.status    = st;
        o.occupancy = OCC_W'(tbl_count);
        o.last      = 1'b1;
        due_results.push_back(o);
    endtask

    // Mostly back-to-back or short gaps, a few long ones, and stretches with none.
    task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                             input logic [VALUE_W-1:0] p, input logic [VALUE_W-1:0] a,
                             input logic [SLOT_W-1:0] s);
        command_t c;
        int       r;
        c.kind     = k;
        c.handle   = h;
        c.period   = p;
        c.argument = a;
        c.slot     = s;
        if (steady_left == 0 && $urandom_range(0, 29) == 0)
            steady_left = $urandom_range(8, 20);
        r = $urandom_range(0, 19);
        if (steady_left > 0)
        begin
            steady_left--;
            c.gap = 0;
        end
        else if (r < 11)
            c.gap = 0;
        else if (r < 18)
            c.gap = $urandom_range(1, 3);
        else
            c.gap = $urandom_range(10, 40);
        cmd_backlog.push_back(c);
    endtask

    // Driver: present the next command on the falling edge once the last one transferred.
    always @(negedge clk)
    begin
        command_t c;
        if (!rst_n)
            start <= 1'b0;
        else if (start && n_taken != n_sent)
        begin
            // hold until the transfer completes
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (cmd_backlog.size() != 0)
        begin
            c = cmd_backlog.pop_front();
            kind     <= c.kind;
            handle   <= c.handle;
            period   <= c.period;
            argument <= c.argument;
            slot     <= c.slot;
            start    <= 1'b1;
            gap_left <= c.gap;
            n_sent   <= n_sent + 1;
        end
        else
            start <= 1'b0;
    end

    // Monitor: check results against the oldest expectation, then predict any new transfer.
    always @(posedge clk)
    begin
        outcome_t want;
        command_t c;
        if (rst_n)
        begin
            if (strobe === 1'b1)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("result with nothing expected", 32'd1, 32'd0);
                else
                begin
                    want = due_results.pop_front();
                    if (fired !== want.fired)
                        flag_mismatch("fired", 32'(fired), 32'(want.fired));
                    if (fired_handle !== want.fired_handle)
                        flag_mismatch("fired_handle", 32'(fired_handle),
                                      32'(want.fired_handle));
                    if (fired_argument !== want.fired_argument)
                        flag_mismatch("fired_argument", 32'(fired_argument),
                                      32'(want.fired_argument));
                    if (fired_urgent !== want.fired_urgent)
                        flag_mismatch("fired_urgent", 32'(fired_urgent),
                                      32'(want.fired_urgent));
                    if (status !== want.status)
                        flag_mismatch("status", 32'(status), 32'(want.status));
                    if (occupancy !== want.occupancy)
                        flag_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
                    if (last !== want.last)
                        flag_mismatch("last", 32'(last), 32'(want.last));
                end
            end
            if (start && !busy)
            begin
                c.kind     = kind;
                c.handle   = handle;
                c.period   = period;
                c.argument = argument;
                c.slot     = slot;
                c.gap      = 0;
                advance_table(c);
                n_taken <= n_taken + 1;
            end
        end
    end

    initial
    begin
        int                  r;
        logic [KIND_W-1:0]   k;
        logic [HANDLE_W-1:0] h;
        logic [VALUE_W-1:0]  p;

        // empty table
        queue_cmd(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_SERVICE, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_REM_SLOT, 8'h00, 16'h0000, 16'h0000, 4'hF);
        queue_cmd(KIND_REM_HANDLE, 8'h00, 16'h0000, 16'h0000, 4'h0);
        // null handle on every add kind
        queue_cmd(KIND_ADD_NORMAL, 8'h00, 16'hFFFF, 16'hFFFF, 4'hF);
        queue_cmd(KIND_ADD_HIGH, 8'h00, 16'h0001, 16'h1234, 4'h0);
        queue_cmd(KIND_ADD_ONCE, 8'h00, 16'h0000, 16'h0000, 4'h0);
        // fill the table; a one-shot at 5 is followed by a due normal at 6
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            k = KIND_W'(KIND_ADD_NORMAL + (i % 3));
            if (i == 0)
                h = 8'hFF;
            else if (i == 1)
                h = 8'h01;
            else if (i == 3 || i == 6 || i == 7)
                h = 8'h5A;
            else
                h = HANDLE_W'(i * 16 + 3);
            if (i == 9)
                p = 16'hFFFF;
            else if (i == 12)
                p = 16'd700;
            else
                p = VALUE_W'(i % 2);
            queue_cmd(k, h, p, (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : VALUE_W'($urandom),
                      SLOT_W'(i));
        end
        queue_cmd(KIND_ADD_HIGH, 8'h33, 16'h0002, 16'h5555, 4'h0);
        queue_cmd(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_SERVICE, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_REM_SLOT, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_REM_HANDLE, 8'h5A, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_REM_SLOT, 8'h00, 16'h0000, 16'h0000, 4'hF);
        queue_cmd(KIND_CLEAR, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_cmd(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);

        // random mix: adds outweigh removals so the table often runs full
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)
            begin
                k = KIND_W'(KIND_ADD_NORMAL + $urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0:       h = 8'h00;
                    1, 2:    h = HANDLE_W'($urandom);
                    default: h = HANDLE_W'($urandom_range(1, 6));
                endcase
                p = ($urandom_range(0, 4) == 0) ? VALUE_W'($urandom)
                                                : VALUE_W'($urandom_range(0, 4));
                queue_cmd(k, h, p, VALUE_W'($urandom), SLOT_W'($urandom));
            end
            else if (r < 68)
                queue_cmd(KIND_TICK, HANDLE_W'($urandom), VALUE_W'($urandom),
                          VALUE_W'($urandom), SLOT_W'($urandom));
            else if (r < 80)
                queue_cmd(KIND_SERVICE, HANDLE_W'($urandom), VALUE_W'($urandom),
                          VALUE_W'($urandom), SLOT_W'($urandom));
            else if (r < 88)
                queue_cmd(KIND_REM_SLOT, HANDLE_W'($urandom), VALUE_W'($urandom),
                          VALUE_W'($urandom), SLOT_W'($urandom));
            else if (r < 97)
                queue_cmd(KIND_REM_HANDLE, HANDLE_W'($urandom_range(0, 6)), VALUE_W'($urandom),
                          VALUE_W'($urandom), SLOT_W'($urandom));
            else
                queue_cmd(KIND_CLEAR, HANDLE_W'($urandom), VALUE_W'($urandom),
                          VALUE_W'($urandom), SLOT_W'($urandom));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || n_taken != n_sent || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            flag_mismatch("results never arrived", 32'(due_results.size()), 32'd0);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
